// File: design/twha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twha_pkg
// Shared constants, register indexes and controller/datapath handshake types
// for the two-window histogram anomaly scorer.
// ---------------------------------------------------------------------------
package twha_pkg;

   localparam int DEF_MAX_BINS        = 64;
   localparam int DEF_MAX_PROJECTIONS = 32;
   localparam int DEF_COUNT_WIDTH     = 16;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BINS_IN_USE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PROJS_IN_USE  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_EMPTY_BIN_LOG = 2'd3;

   localparam logic [15:0] RST_WINDOW_SIZE   = 16'd256;
   localparam logic [6:0]  RST_BINS_IN_USE   = 7'd64;
   localparam logic [5:0]  RST_PROJS_IN_USE  = 6'd32;
   localparam logic [23:0] RST_EMPTY_BIN_LOG = 24'hF1C0B5;   // -933707

   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam int          LOG_STEPS = 16;
   localparam int          DIV_STEPS = 32;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_SCALE  = 1'b1;

   typedef struct packed {
      logic accept;
      logic load_scale;
      logic mem_read;
      logic mem_write;
      logic acc_empty;
      logic log_start;
      logic log_step;
      logic log_mul;
      logic acc_log;
      logic advance;
      logic div_step;
      logic emit;
      logic clr_step;
   } twha_cmd_type;

   typedef struct packed {
      logic kind;
      logic in_range;
      logic count_zero;
      logic sample_end;
      logic rsp_free;
      logic clr_last;
      logic window_end;
   } twha_status_type;

endpackage
`default_nettype wire

// File: design/twha_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twha interfaces
// Valid/ready channels for the input words and the result words.
// ---------------------------------------------------------------------------
interface twha_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  bin_index;
   logic [4:0]  projection_slot;
   logic signed [23:0] scale_value;

   modport source (output valid, kind, bin_index, projection_slot, scale_value,
                   input ready);
   modport sink   (input valid, kind, bin_index, projection_slot, scale_value,
                   output ready);
endinterface

interface twha_rsp_if;
   logic        valid;
   logic        ready;
   logic signed [23:0] score;
   logic        window_switched;

   modport source (output valid, score, window_switched, input ready);
   modport sink   (input valid, score, window_switched, output ready);
endinterface
`default_nettype wire

// File: design/twha_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twha_ctrl
// Sequencer: clear sweeps, bin lookup, log iterations, divide and emit.
// ---------------------------------------------------------------------------
module twha_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  twha_pkg::twha_status_type sts,
   output twha_pkg::twha_cmd_type    cmd
);
   import twha_pkg::*;

   localparam logic [3:0] S_CLR    = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_READ   = 4'd3;
   localparam logic [3:0] S_LOG    = 4'd4;
   localparam logic [3:0] S_MUL    = 4'd5;
   localparam logic [3:0] S_ACC    = 4'd6;
   localparam logic [3:0] S_ADV    = 4'd7;
   localparam logic [3:0] S_DIV    = 4'd8;
   localparam logic [3:0] S_EMIT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.kind == KIND_SCALE) begin
               cmd.load_scale = 1'b1;
               state_in       = S_IDLE;
            end else if (sts.in_range) begin
               cmd.mem_read = 1'b1;
               state_in     = S_READ;
            end else begin
               state_in = S_ADV;
            end
         end
         S_READ: begin
            cmd.mem_write = 1'b1;
            if (sts.count_zero) begin
               cmd.acc_empty = 1'b1;
               state_in      = S_ADV;
            end else begin
               cmd.log_start = 1'b1;
               cnt_in        = '0;
               state_in      = S_LOG;
            end
         end
         S_LOG: begin
            cmd.log_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(LOG_STEPS - 1)) state_in = S_MUL;
         end
         S_MUL: begin
            cmd.log_mul = 1'b1;
            state_in    = S_ACC;
         end
         S_ACC: begin
            cmd.acc_log = 1'b1;
            state_in    = S_ADV;
         end
         S_ADV: begin
            cmd.advance = 1'b1;
            cnt_in      = '0;
            state_in    = sts.sample_end ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = sts.window_end ? S_CLR : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// File: design/twha_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// twha_datapath
// Count memory, scale table, log unit, accumulator, divider, result register.
// ---------------------------------------------------------------------------
module twha_datapath #(
   parameter int MAX_BINS        = twha_pkg::DEF_MAX_BINS,
   parameter int MAX_PROJECTIONS = twha_pkg::DEF_MAX_PROJECTIONS,
   parameter int COUNT_WIDTH     = twha_pkg::DEF_COUNT_WIDTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       csr_we,
   input  wire [twha_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [twha_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                       in_kind,
   input  wire [7:0]                 in_bin_index,
   input  wire [4:0]                 in_projection_slot,
   input  wire [23:0]                in_scale_value,
   input  wire                       rsp_ready,
   output logic                      rsp_valid,
   output logic [23:0]               rsp_score,
   output logic                      rsp_window_switched,
   input  twha_pkg::twha_cmd_type    cmd,
   output twha_pkg::twha_status_type sts
);
   import twha_pkg::*;

   localparam int PROJ_W = (MAX_PROJECTIONS > 1) ? $clog2(MAX_PROJECTIONS) : 1;
   localparam int BIN_W  = $clog2(MAX_BINS);
   localparam int POS_W  = $clog2(MAX_PROJECTIONS + 1);
   localparam int OFF_W  = PROJ_W + BIN_W;
   localparam int ADDR_W = OFF_W + 1;

   // configuration
   logic [15:0] wsize_ff;
   logic [6:0]  nbins_ff;
   logic [5:0]  nproj_ff;
   logic [23:0] empty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wsize_ff <= RST_WINDOW_SIZE;
         nbins_ff <= RST_BINS_IN_USE;
         nproj_ff <= RST_PROJS_IN_USE;
         empty_ff <= RST_EMPTY_BIN_LOG;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WINDOW_SIZE:   wsize_ff <= csr_wdata[15:0];
            REG_BINS_IN_USE:   nbins_ff <= csr_wdata[6:0];
            REG_PROJS_IN_USE:  nproj_ff <= csr_wdata[5:0];
            REG_EMPTY_BIN_LOG: empty_ff <= csr_wdata;
            default:           wsize_ff <= wsize_ff;
         endcase
      end
   end

   logic [31:0] nbins_eff, nproj_eff, wsize_eff;
   always_comb begin
      nbins_eff = 32'(nbins_ff);
      if (nbins_eff == 0) nbins_eff = 32'd1;
      if (nbins_eff > 32'(MAX_BINS)) nbins_eff = 32'(MAX_BINS);
      nproj_eff = 32'(nproj_ff);
      if (nproj_eff == 0) nproj_eff = 32'd1;
      if (nproj_eff > 32'(MAX_PROJECTIONS)) nproj_eff = 32'(MAX_PROJECTIONS);
      wsize_eff = (wsize_ff == 16'd0) ? 32'd1 : 32'(wsize_ff);
   end

   // input word
   logic        kind_ff;
   logic [7:0]  bin_ff;
   logic [4:0]  slot_ff;
   logic [23:0] scale_in_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff     <= in_kind;
         bin_ff      <= in_bin_index;
         slot_ff     <= in_projection_slot;
         scale_in_ff <= in_scale_value;
      end
   end

   // sample state
   logic [POS_W-1:0] pos_ff;
   logic [15:0]      samples_ff;
   logic             bank_ff;
   logic signed [31:0] sum_ff;

   logic [PROJ_W+7:0] pos_ext;
   logic [BIN_W+7:0]  bin_ext;
   logic [PROJ_W+4:0] slot_ext;
   logic [OFF_W-1:0]  offset;
   assign pos_ext  = (PROJ_W + 8)'(pos_ff);
   assign bin_ext  = (BIN_W + 8)'(bin_ff);
   assign slot_ext = (PROJ_W + 5)'(slot_ff);
   assign offset   = {pos_ext[PROJ_W-1:0], bin_ext[BIN_W-1:0]};

   // scale table
   logic [23:0] scale_mem [MAX_PROJECTIONS];
   logic [23:0] scale_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_scale && (32'(slot_ff) < 32'(MAX_PROJECTIONS)))
         scale_mem[slot_ext[PROJ_W-1:0]] <= scale_in_ff;
      if (cmd.mem_read)
         scale_rd_ff <= scale_mem[pos_ext[PROJ_W-1:0]];
   end

   // count memory
   logic [COUNT_WIDTH-1:0] cnt_mem [2**ADDR_W];
   logic [COUNT_WIDTH-1:0] rd_cnt_ff, up_cnt_ff;
   logic [ADDR_W-1:0]      clr_addr_ff;
   logic                   clr_all_ff;
   logic [ADDR_W-1:0]      wr_addr;
   logic [COUNT_WIDTH-1:0] wr_data;
   logic                   wr_en;

   always_comb begin
      wr_en   = cmd.clr_step || cmd.mem_write;
      wr_addr = cmd.clr_step ? clr_addr_ff : {~bank_ff, offset};
      if (cmd.clr_step) wr_data = '0;
      else if (&up_cnt_ff) wr_data = up_cnt_ff;
      else wr_data = up_cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) cnt_mem[wr_addr] <= wr_data;
      if (cmd.mem_read) begin
         rd_cnt_ff <= cnt_mem[{bank_ff, offset}];
         up_cnt_ff <= cnt_mem[{~bank_ff, offset}];
      end
   end

   // log unit
   logic [4:0]  k_val;
   logic [31:0] norm;
   logic [30:0] m_ff;
   logic [4:0]  k_ff;
   logic [15:0] frac_ff;
   logic [52:0] prod_ff;
   logic [61:0] sq;
   logic [31:0] m2;
   logic [16:0] ln_val;
   logic [52:0] prod_rnd;

   always_comb begin
      k_val = '0;
      for (int i = 0; i < COUNT_WIDTH; i++)
         if (rd_cnt_ff[i]) k_val = 5'(i);
      norm     = 32'(rd_cnt_ff) << (5'd31 - k_val);
      sq       = 62'(m_ff) * 62'(m_ff);
      m2       = sq[61:30];
      prod_rnd = prod_ff + (53'd1 << 35);
      ln_val   = prod_rnd[52:36];
   end

   always_ff @(posedge clock) begin
      if (cmd.log_start) begin
         m_ff    <= norm[31:1];
         k_ff    <= k_val;
         frac_ff <= '0;
      end else if (cmd.log_step) begin
         m_ff    <= m2[31] ? m2[31:1] : m2[30:0];
         frac_ff <= {frac_ff[14:0], m2[31]};
      end
      if (cmd.log_mul)
         prod_ff <= 53'({k_ff, frac_ff}) * 53'(LN2_Q32);
   end

   // accumulator
   logic signed [33:0] delta, acc;
   logic signed [31:0] acc_sat;
   always_comb begin
      if (cmd.acc_empty) delta = 34'(signed'(empty_ff));
      else delta = signed'(34'(ln_val)) - 34'(signed'(scale_rd_ff));
      acc = 34'(sum_ff) + delta;
      if (acc > 34'sd2147483647) acc_sat = 32'sh7FFFFFFF;
      else if (acc < -34'sd2147483648) acc_sat = 32'sh80000000;
      else acc_sat = acc[31:0];
   end

   // divider
   logic [31:0]      dvd_ff;
   logic [POS_W-1:0] rem_ff;
   logic             neg_ff;
   logic [POS_W:0]   rem_sh;
   logic             qbit;
   logic             sample_end, window_end;
   logic [31:0]      sum_mag;

   always_comb begin
      rem_sh     = {rem_ff, dvd_ff[31]};
      qbit       = (32'(rem_sh) >= nproj_eff);
      sample_end = (32'(pos_ff) + 32'd1) >= nproj_eff;
      window_end = (32'(samples_ff) + 32'd1) >= wsize_eff;
      sum_mag    = sum_ff[31] ? (32'd0 - 32'(sum_ff)) : 32'(sum_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.advance && sample_end) begin
         dvd_ff <= sum_mag;
         neg_ff <= sum_ff[31];
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= qbit ? POS_W'(32'(rem_sh) - nproj_eff) : rem_sh[POS_W-1:0];
         dvd_ff <= {dvd_ff[30:0], qbit};
      end
   end

   // result scaling
   logic [23:0] score_val;
   always_comb begin
      if (neg_ff) begin
         if (dvd_ff > 32'd8388608) score_val = 24'h800000;
         else score_val = 24'd0 - dvd_ff[23:0];
      end else begin
         if (dvd_ff > 32'd8388607) score_val = 24'h7FFFFF;
         else score_val = dvd_ff[23:0];
      end
   end

   // sequencing state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         samples_ff  <= '0;
         bank_ff     <= 1'b0;
         sum_ff      <= '0;
         clr_addr_ff <= '0;
         clr_all_ff  <= 1'b1;
         rsp_valid   <= 1'b0;
      end else begin
         if (cmd.acc_empty || cmd.acc_log) sum_ff <= acc_sat;
         if (cmd.advance) begin
            if (sample_end) begin
               pos_ff <= '0;
               sum_ff <= '0;
            end else begin
               pos_ff <= pos_ff + 1'b1;
            end
         end
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + 1'b1;
         if (cmd.emit) begin
            rsp_valid           <= 1'b1;
            rsp_score           <= score_val;
            rsp_window_switched <= window_end;
            if (window_end) begin
               samples_ff  <= '0;
               bank_ff     <= ~bank_ff;
               clr_addr_ff <= {bank_ff, {OFF_W{1'b0}}};
               clr_all_ff  <= 1'b0;
            end else begin
               samples_ff <= samples_ff + 16'd1;
            end
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.kind       = kind_ff;
      sts.in_range   = (32'(pos_ff) < 32'(MAX_PROJECTIONS)) && (32'(bin_ff) < nbins_eff);
      sts.count_zero = (rd_cnt_ff == '0);
      sts.sample_end = sample_end;
      sts.rsp_free   = !rsp_valid || rsp_ready;
      sts.window_end = window_end;
      if (clr_all_ff) sts.clr_last = &clr_addr_ff;
      else sts.clr_last = &clr_addr_ff[OFF_W-1:0];
   end

endmodule
`default_nettype wire

// File: design/two_window_histogram_anomaly_score_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Scale words load the table; skipped bins only advance; empty bins add
// the empty-bin log; counted bins run the log unit. A sample's last projection
// also runs the divider and emits. One word is in flight at a time;
// the 16-squaring log unit, 32-step divider and emit stalls set the rate.
// Reset clears both count banks.
// A window swap clears the new updating bank.
// ---------------------------------------------------------------------------
// two_window_histogram_anomaly_score_top
// Streaming histogram anomaly scorer with swapping count banks.
// ---------------------------------------------------------------------------
module two_window_histogram_anomaly_score_top #(
   parameter int MAX_BINS        = twha_pkg::DEF_MAX_BINS,
   parameter int MAX_PROJECTIONS = twha_pkg::DEF_MAX_PROJECTIONS,
   parameter int COUNT_WIDTH     = twha_pkg::DEF_COUNT_WIDTH
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             csr_we,
   input  wire [twha_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [twha_pkg::CSR_DATA_W-1:0]  csr_wdata,
   twha_req_if.sink                        req_ch,
   twha_rsp_if.source                      rsp_ch
);
   import twha_pkg::*;

   twha_cmd_type    cmd;
   twha_status_type sts;
   logic [23:0]     score_w;

   twha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   twha_datapath #(
      .MAX_BINS        (MAX_BINS),
      .MAX_PROJECTIONS (MAX_PROJECTIONS),
      .COUNT_WIDTH     (COUNT_WIDTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .in_kind             (req_ch.kind),
      .in_bin_index        (req_ch.bin_index),
      .in_projection_slot  (req_ch.projection_slot),
      .in_scale_value      (req_ch.scale_value),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_score           (score_w),
      .rsp_window_switched (rsp_ch.window_switched),
      .cmd                 (cmd),
      .sts                 (sts)
   );

   assign rsp_ch.score = score_w;

endmodule
`default_nettype wire
